### rtl/urlrb_pkg.sv
// Package for the receive ring buffer with line assembly.
// Holds command, operation and status codes, byte constants and the queue record types.
package urlrb_pkg;

    localparam int CHARS_W = 7;
    localparam int MID_Q_DEPTH = 2;
    localparam int OUT_Q_DEPTH = 4;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_BYTE  = 2'd0;
    localparam t_cmd CMD_POP   = 2'd1;
    localparam t_cmd CMD_FLUSH = 2'd2;

    typedef logic [2:0] t_op;
    localparam t_op OP_NOP        = 3'd0;
    localparam t_op OP_BYTE_ASCII = 3'd1;
    localparam t_op OP_BYTE_RAW   = 3'd2;
    localparam t_op OP_LINE_END   = 3'd3;
    localparam t_op OP_POP        = 3'd4;
    localparam t_op OP_FLUSH      = 3'd5;

    typedef logic [2:0] t_status;
    localparam t_status ST_STORED  = 3'd0;
    localparam t_status ST_TRUNC   = 3'd1;
    localparam t_status ST_FULL    = 3'd2;
    localparam t_status ST_SUPP    = 3'd3;
    localparam t_status ST_POPPED  = 3'd4;
    localparam t_status ST_EMPTY   = 3'd5;
    localparam t_status ST_FLUSHED = 3'd6;

    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_SUB = 8'h1A;
    localparam logic [7:0] BYTE_NUL = 8'h00;

    typedef logic [CHARS_W-1:0] t_chars;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] read_data;
        logic       line_complete;
        t_chars     chars_held;
    } t_result;

endpackage

### rtl/urlrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module urlrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/urlrb_fifo.sv
// Small generic register FIFO with full and almost-full flags.
// No dependencies.
module urlrb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_almost_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_AFULL = CW'(DEPTH - 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    n_wptr;
    logic [PW-1:0]    r_rptr;
    logic [PW-1:0]    n_rptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full        = (r_count == CNT_FULL);
    assign o_almost_full = (r_count >= CNT_AFULL);
    assign o_empty       = (r_count == '0);
    assign o_data        = r_slot[r_rptr];
    assign do_push       = i_push && !o_full;
    assign do_pop        = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/urlrb_front.sv
// Front end: accepts commands, holds the mode register and classifies each transaction.
// Depends on urlrb_pkg and urlrb_fifo.
module urlrb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [1:0]            i_cmd,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_ascii_mode,
    output urlrb_pkg::t_item      o_item,
    output logic                  o_item_valid,
    input  logic                  i_item_pop
);

    logic             r_ascii_mode;
    urlrb_pkg::t_item cls_item;
    logic             mid_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ascii_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_ascii_mode <= i_cfg_ascii_mode;
        end
    end

    always_comb begin
        cls_item.data_byte = i_data_byte;
        cls_item.op        = urlrb_pkg::OP_NOP;
        unique case (i_cmd)
            urlrb_pkg::CMD_BYTE: begin
                if (!r_ascii_mode) begin
                    cls_item.op = urlrb_pkg::OP_BYTE_RAW;
                end else if (i_data_byte == urlrb_pkg::BYTE_LF
                             || i_data_byte == urlrb_pkg::BYTE_CR) begin
                    cls_item.op = urlrb_pkg::OP_LINE_END;
                end else if (i_data_byte == urlrb_pkg::BYTE_NUL
                             || i_data_byte == urlrb_pkg::BYTE_SUB) begin
                    cls_item.op = urlrb_pkg::OP_NOP;
                end else begin
                    cls_item.op = urlrb_pkg::OP_BYTE_ASCII;
                end
            end
            urlrb_pkg::CMD_POP: begin
                cls_item.op = urlrb_pkg::OP_POP;
            end
            urlrb_pkg::CMD_FLUSH: begin
                cls_item.op = urlrb_pkg::OP_FLUSH;
            end
            default: begin
                cls_item.op = urlrb_pkg::OP_NOP;
            end
        endcase
    end

    urlrb_fifo #(
        .WIDTH ($bits(urlrb_pkg::t_item)),
        .DEPTH (urlrb_pkg::MID_Q_DEPTH)
    ) u_mid_q (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_data        (cls_item),
        .o_full        (o_full),
        .o_almost_full (),
        .i_pop         (i_item_pop),
        .o_data        (o_item),
        .o_empty       (mid_empty)
    );

    assign o_item_valid = !mid_empty;

endmodule

### rtl/urlrb_back.sv
// Back end: executes classified transactions against the ring and its indices.
// Depends on urlrb_pkg and urlrb_ram.
module urlrb_back #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  urlrb_pkg::t_item   i_item,
    input  logic               i_item_valid,
    output logic               o_item_pop,
    output logic               o_res_push,
    output urlrb_pkg::t_result o_res,
    input  logic               i_res_full,
    input  logic               i_res_almost_full
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW:0] DEPTH_W = (IW + 1)'(DEPTH);

    logic [IW-1:0]       r_wr_idx;
    logic [IW-1:0]       n_wr_idx;
    logic [IW-1:0]       r_rd_idx;
    logic [IW-1:0]       n_rd_idx;
    logic [7:0]          r_line_len;
    logic [7:0]          n_line_len;
    logic                r_s2_valid;
    urlrb_pkg::t_status  r_s2_status;
    urlrb_pkg::t_status  n_s2_status;
    logic                r_s2_done;
    logic                n_s2_done;
    urlrb_pkg::t_chars   r_s2_chars;
    urlrb_pkg::t_chars   n_s2_chars;
    logic                r_s2_pop;
    logic                issue_ok;
    logic                go;
    logic [IW:0]         wr_p1;
    logic [IW:0]         wr_p2;
    logic [IW-1:0]       wr_inc;
    logic [IW-1:0]       wr_two;
    logic [IW:0]         rd_p1;
    logic [IW-1:0]       rd_inc;
    logic                full_c;
    logic                trunc_c;
    logic [7:0]          line_bump;
    logic                we;
    logic [7:0]          wdata;
    logic [IW:0]         occ;
    logic [7:0]          ram_q;

    assign issue_ok   = r_s2_valid ? !i_res_almost_full : !i_res_full;
    assign go         = i_item_valid && issue_ok;
    assign o_item_pop = go;

    assign wr_p1   = {1'b0, r_wr_idx} + (IW + 1)'(1);
    assign wr_p2   = {1'b0, r_wr_idx} + (IW + 1)'(2);
    assign wr_inc  = (wr_p1 >= DEPTH_W) ? IW'(wr_p1 - DEPTH_W) : wr_p1[IW-1:0];
    assign wr_two  = (wr_p2 >= DEPTH_W) ? IW'(wr_p2 - DEPTH_W) : wr_p2[IW-1:0];
    assign rd_p1   = {1'b0, r_rd_idx} + (IW + 1)'(1);
    assign rd_inc  = (rd_p1 >= DEPTH_W) ? IW'(rd_p1 - DEPTH_W) : rd_p1[IW-1:0];
    assign full_c  = (wr_inc == r_rd_idx);
    assign trunc_c = (wr_two == r_rd_idx);
    assign line_bump = (r_line_len == 8'hFF) ? r_line_len : r_line_len + 8'd1;

    always_comb begin
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_line_len  = r_line_len;
        n_s2_status = urlrb_pkg::ST_SUPP;
        n_s2_done   = 1'b0;
        we          = 1'b0;
        wdata       = urlrb_pkg::BYTE_NUL;
        if (go) begin
            unique case (i_item.op)
                urlrb_pkg::OP_BYTE_ASCII: begin
                    if (trunc_c) begin
                        we          = 1'b1;
                        n_wr_idx    = wr_inc;
                        n_s2_status = urlrb_pkg::ST_TRUNC;
                        n_s2_done   = 1'b1;
                        n_line_len  = 8'd0;
                    end else if (full_c) begin
                        n_s2_status = urlrb_pkg::ST_FULL;
                    end else begin
                        we          = 1'b1;
                        wdata       = i_item.data_byte;
                        n_wr_idx    = wr_inc;
                        n_s2_status = urlrb_pkg::ST_STORED;
                        n_line_len  = line_bump;
                    end
                end
                urlrb_pkg::OP_BYTE_RAW: begin
                    if (trunc_c) begin
                        we          = 1'b1;
                        n_wr_idx    = wr_inc;
                        n_s2_status = urlrb_pkg::ST_TRUNC;
                    end else if (full_c) begin
                        n_s2_status = urlrb_pkg::ST_FULL;
                    end else begin
                        we          = 1'b1;
                        wdata       = i_item.data_byte;
                        n_wr_idx    = wr_inc;
                        n_s2_status = urlrb_pkg::ST_STORED;
                        n_line_len  = line_bump;
                    end
                end
                urlrb_pkg::OP_LINE_END: begin
                    if (r_line_len == 8'd0) begin
                        n_s2_status = urlrb_pkg::ST_SUPP;
                    end else if (trunc_c) begin
                        we          = 1'b1;
                        n_wr_idx    = wr_inc;
                        n_s2_status = urlrb_pkg::ST_TRUNC;
                        n_s2_done   = 1'b1;
                        n_line_len  = 8'd0;
                    end else if (full_c) begin
                        n_s2_status = urlrb_pkg::ST_FULL;
                    end else begin
                        we          = 1'b1;
                        n_wr_idx    = wr_inc;
                        n_s2_status = urlrb_pkg::ST_STORED;
                        n_s2_done   = 1'b1;
                        n_line_len  = 8'd0;
                    end
                end
                urlrb_pkg::OP_POP: begin
                    if (r_rd_idx == r_wr_idx) begin
                        n_s2_status = urlrb_pkg::ST_EMPTY;
                    end else begin
                        n_rd_idx    = rd_inc;
                        n_s2_status = urlrb_pkg::ST_POPPED;
                    end
                end
                urlrb_pkg::OP_FLUSH: begin
                    n_wr_idx    = '0;
                    n_rd_idx    = '0;
                    n_line_len  = 8'd0;
                    n_s2_status = urlrb_pkg::ST_FLUSHED;
                end
                default: begin
                    n_s2_status = urlrb_pkg::ST_SUPP;
                end
            endcase
        end
    end

    assign occ = (n_wr_idx >= n_rd_idx)
               ? ({1'b0, n_wr_idx} - {1'b0, n_rd_idx})
               : ({1'b0, n_wr_idx} + DEPTH_W - {1'b0, n_rd_idx});
    assign n_s2_chars = urlrb_pkg::t_chars'(occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_line_len <= 8'd0;
            r_s2_valid <= 1'b0;
        end else begin
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_line_len <= n_line_len;
            r_s2_valid <= go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_status <= n_s2_status;
        r_s2_done   <= n_s2_done;
        r_s2_chars  <= n_s2_chars;
        r_s2_pop    <= (n_s2_status == urlrb_pkg::ST_POPPED);
    end

    urlrb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wr_idx),
        .i_wdata (wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_q)
    );

    assign o_res_push          = r_s2_valid;
    assign o_res.status        = r_s2_status;
    assign o_res.read_data     = r_s2_pop ? ram_q : urlrb_pkg::BYTE_NUL;
    assign o_res.line_complete = r_s2_done;
    assign o_res.chars_held    = r_s2_chars;

endmodule

### rtl/uart_rx_line_ring_buffer_core.sv
// Top level of the receive ring buffer with line assembly.
// Depends on urlrb_pkg, urlrb_front, urlrb_back and urlrb_fifo.
//
// Usage:
//   Commands enter through a queue-style port: drive i_cmd and i_data_byte with
//   push high; the transaction is taken at an edge where full is low. Command 0
//   delivers a received byte, 1 pops one stored byte, 2 flushes the buffer.
//   Every command yields exactly one result, in order, on o_status, o_read_data,
//   o_line_complete and o_chars_held while empty is low; pop takes it.
//   The ascii_mode register is written through i_cfg_valid / o_cfg_ready with
//   i_cfg_ascii_mode; o_cfg_ready is always high. Write it only while idle.
//   Throughput: one command per cycle while results are popped, set by
//   the back end's one ring access (one RAM write port and one registered read
//   port) per cycle; results pass the back end's registers and the result queue.
//   Reset clears the indices, the line length and both queues and sets ASCII
//   mode; ring contents are not cleared and are never read before written.
//   When the result side stalls, the result queue fills, the back end holds,
//   the command queue fills and full rises; nothing is lost.
module uart_rx_line_ring_buffer_core #(
    parameter int DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] o_status,
    output logic [7:0] o_read_data,
    output logic       o_line_complete,
    output logic [6:0] o_chars_held,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_ascii_mode
);

    urlrb_pkg::t_item   item;
    logic               item_valid;
    logic               item_pop;
    logic               res_push;
    urlrb_pkg::t_result res_in;
    urlrb_pkg::t_result res_out;
    logic               res_full;
    logic               res_almost_full;

    urlrb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_cmd            (i_cmd),
        .i_data_byte      (i_data_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_ascii_mode (i_cfg_ascii_mode),
        .o_item           (item),
        .o_item_valid     (item_valid),
        .i_item_pop       (item_pop)
    );

    urlrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item            (item),
        .i_item_valid      (item_valid),
        .o_item_pop        (item_pop),
        .o_res_push        (res_push),
        .o_res             (res_in),
        .i_res_full        (res_full),
        .i_res_almost_full (res_almost_full)
    );

    urlrb_fifo #(
        .WIDTH ($bits(urlrb_pkg::t_result)),
        .DEPTH (urlrb_pkg::OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (res_push),
        .i_data        (res_in),
        .o_full        (res_full),
        .o_almost_full (res_almost_full),
        .i_pop         (pop),
        .o_data        (res_out),
        .o_empty       (empty)
    );

    assign o_status        = res_out.status;
    assign o_read_data     = res_out.read_data;
    assign o_line_complete = res_out.line_complete;
    assign o_chars_held    = res_out.chars_held;

endmodule

### test/tb_uart_rx_line_ring_buffer_core.sv
`timescale 1ns / 1ps
// Self-checking bench for uart_rx_line_ring_buffer_core: directed table, then random phases.
// Depends on urlrb_pkg and the block; keeps its own ring copy to predict every result.
module tb_uart_rx_line_ring_buffer_core;

    localparam urlrb_pkg::t_cmd CMD_NOP = 2'd3;
    localparam int RING_DEPTH = 128;
    localparam int IDLE_LIMIT = 1000;
    localparam int STREAM_TARGET = 270;

    typedef enum {PH_FILL, PH_STREAM, PH_MIXED} t_phase_kind;

    typedef struct packed {
        logic               ascii;
        urlrb_pkg::t_cmd    cmd;
        logic [7:0]         data;
        logic               lit;
        urlrb_pkg::t_result res;
    } t_row;

    localparam t_row DIRECTED [25] = '{
        '{1'b1, urlrb_pkg::CMD_POP, 8'h00, 1'b1,
          '{urlrb_pkg::ST_EMPTY, 8'h00, 1'b0, 7'd0}},
        '{1'b1, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_LF, 1'b1,
          '{urlrb_pkg::ST_SUPP, 8'h00, 1'b0, 7'd0}},
        '{1'b1, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_NUL, 1'b1,
          '{urlrb_pkg::ST_SUPP, 8'h00, 1'b0, 7'd0}},
        '{1'b1, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_SUB, 1'b1,
          '{urlrb_pkg::ST_SUPP, 8'h00, 1'b0, 7'd0}},
        '{1'b1, urlrb_pkg::CMD_BYTE, 8'h41, 1'b1,
          '{urlrb_pkg::ST_STORED, 8'h00, 1'b0, 7'd1}},
        '{1'b1, urlrb_pkg::CMD_BYTE, 8'hFF, 1'b1,
          '{urlrb_pkg::ST_STORED, 8'h00, 1'b0, 7'd2}},
        '{1'b1, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_CR, 1'b1,
          '{urlrb_pkg::ST_STORED, 8'h00, 1'b1, 7'd3}},
        '{1'b1, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_CR, 1'b1,
          '{urlrb_pkg::ST_SUPP, 8'h00, 1'b0, 7'd3}},
        '{1'b1, CMD_NOP, 8'h55, 1'b1,
          '{urlrb_pkg::ST_SUPP, 8'h00, 1'b0, 7'd3}},
        '{1'b1, urlrb_pkg::CMD_POP, 8'hAA, 1'b1,
          '{urlrb_pkg::ST_POPPED, 8'h41, 1'b0, 7'd2}},
        '{1'b1, urlrb_pkg::CMD_POP, 8'h00, 1'b1,
          '{urlrb_pkg::ST_POPPED, 8'hFF, 1'b0, 7'd1}},
        '{1'b1, urlrb_pkg::CMD_POP, 8'h00, 1'b1,
          '{urlrb_pkg::ST_POPPED, 8'h00, 1'b0, 7'd0}},
        '{1'b1, urlrb_pkg::CMD_POP, 8'hFF, 1'b1,
          '{urlrb_pkg::ST_EMPTY, 8'h00, 1'b0, 7'd0}},
        '{1'b1, urlrb_pkg::CMD_BYTE, 8'h7E, 1'b0, '0},
        '{1'b1, urlrb_pkg::CMD_BYTE, 8'h01, 1'b0, '0},
        '{1'b0, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_NUL, 1'b0, '0},
        '{1'b0, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_LF, 1'b0, '0},
        '{1'b0, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_SUB, 1'b0, '0},
        '{1'b0, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_CR, 1'b0, '0},
        '{1'b1, urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_LF, 1'b0, '0},
        '{1'b1, urlrb_pkg::CMD_POP, 8'h00, 1'b0, '0},
        '{1'b1, urlrb_pkg::CMD_FLUSH, 8'h00, 1'b1,
          '{urlrb_pkg::ST_FLUSHED, 8'h00, 1'b0, 7'd0}},
        '{1'b1, urlrb_pkg::CMD_POP, 8'h00, 1'b1,
          '{urlrb_pkg::ST_EMPTY, 8'h00, 1'b0, 7'd0}},
        '{1'b1, urlrb_pkg::CMD_BYTE, 8'h80, 1'b0, '0},
        '{1'b1, urlrb_pkg::CMD_FLUSH, 8'hFF, 1'b1,
          '{urlrb_pkg::ST_FLUSHED, 8'h00, 1'b0, 7'd0}}
    };

    localparam t_phase_kind PHASE_KIND [5] = '{PH_FILL, PH_FILL, PH_STREAM, PH_MIXED, PH_MIXED};
    localparam logic PHASE_MODE [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam int PHASE_LEN [5] = '{230, 230, 0, 120, 120};

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] i_cmd = urlrb_pkg::CMD_BYTE;
    logic [7:0] i_data_byte = 8'h00;
    logic       empty;
    logic       pop = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_read_data;
    logic       o_line_complete;
    logic [6:0] o_chars_held;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_ascii_mode = 1'b1;

    logic [7:0]        ring_copy [RING_DEPTH];
    urlrb_pkg::t_chars wr_ptr = '0;
    urlrb_pkg::t_chars rd_ptr = '0;
    logic [7:0]        open_line_len = 8'd0;
    logic              ascii_on = 1'b1;

    urlrb_pkg::t_result pending_results [$];
    int      fault_count = 0;
    int      tx_calm = 0;
    int      rx_calm = 0;
    int      rx_gap = 0;
    int      idle_cycles = 0;

    uart_rx_line_ring_buffer_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_data_byte     (i_data_byte),
        .empty           (empty),
        .pop             (pop),
        .o_status        (o_status),
        .o_read_data     (o_read_data),
        .o_line_complete (o_line_complete),
        .o_chars_held    (o_chars_held),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_ascii_mode(i_cfg_ascii_mode)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic urlrb_pkg::t_status ring_put(input logic [7:0] b);
        if (urlrb_pkg::t_chars'(wr_ptr + 7'd2) == rd_ptr) begin
            ring_copy[wr_ptr] = urlrb_pkg::BYTE_NUL;
            wr_ptr = wr_ptr + 7'd1;
            return urlrb_pkg::ST_TRUNC;
        end
        if (urlrb_pkg::t_chars'(wr_ptr + 7'd1) == rd_ptr)
            return urlrb_pkg::ST_FULL;
        ring_copy[wr_ptr] = b;
        wr_ptr = wr_ptr + 7'd1;
        return urlrb_pkg::ST_STORED;
    endfunction

    function automatic urlrb_pkg::t_result predict_ring_result(input urlrb_pkg::t_cmd cmd,
                                                               input logic [7:0] b);
        urlrb_pkg::t_result r;
        r = '0;
        r.status = urlrb_pkg::ST_SUPP;
        case (cmd)
            urlrb_pkg::CMD_BYTE: begin
                if (!ascii_on) begin
                    r.status = ring_put(b);
                    if (r.status == urlrb_pkg::ST_STORED && open_line_len != 8'hFF)
                        open_line_len = open_line_len + 8'd1;
                end else if (b == urlrb_pkg::BYTE_LF || b == urlrb_pkg::BYTE_CR) begin
                    if (open_line_len != 8'd0) begin
                        r.status = ring_put(urlrb_pkg::BYTE_NUL);
                        if (r.status != urlrb_pkg::ST_FULL) begin
                            r.line_complete = 1'b1;
                            open_line_len = 8'd0;
                        end
                    end
                end else if (b != urlrb_pkg::BYTE_NUL && b != urlrb_pkg::BYTE_SUB) begin
                    r.status = ring_put(b);
                    if (r.status == urlrb_pkg::ST_STORED) begin
                        if (open_line_len != 8'hFF)
                            open_line_len = open_line_len + 8'd1;
                    end else if (r.status == urlrb_pkg::ST_TRUNC) begin
                        r.line_complete = 1'b1;
                        open_line_len = 8'd0;
                    end
                end
            end
            urlrb_pkg::CMD_POP: begin
                if (rd_ptr == wr_ptr) begin
                    r.status = urlrb_pkg::ST_EMPTY;
                end else begin
                    r.read_data = ring_copy[rd_ptr];
                    rd_ptr = rd_ptr + 7'd1;
                    r.status = urlrb_pkg::ST_POPPED;
                end
            end
            urlrb_pkg::CMD_FLUSH: begin
                wr_ptr = '0;
                rd_ptr = '0;
                open_line_len = 8'd0;
                r.status = urlrb_pkg::ST_FLUSHED;
            end
            default: ;
        endcase
        r.chars_held = wr_ptr - rd_ptr;
        return r;
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 62)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return urlrb_pkg::BYTE_LF;
        if (r < 10)
            return urlrb_pkg::BYTE_CR;
        if (r < 14)
            return urlrb_pkg::BYTE_NUL;
        if (r < 18)
            return urlrb_pkg::BYTE_SUB;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    task automatic send_cmd(input urlrb_pkg::t_cmd cmd, input logic [7:0] b, input logic lit,
                            input urlrb_pkg::t_result lit_res);
        urlrb_pkg::t_result pred;
        i_cmd <= cmd;
        i_data_byte <= b;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        pred = predict_ring_result(cmd, b);
        pending_results.push_back(lit ? lit_res : pred);
    endtask

    task automatic hold_push();
        int gap;
        gap = pick_gap(tx_calm);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_ascii_mode(input logic mode);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_ascii_mode <= mode;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ascii_on = mode;
    endtask

    // result side: random pop stalls
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                rx_gap = pick_gap(rx_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        urlrb_pkg::t_result seen;
        urlrb_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            seen = '{o_status, o_read_data, o_line_complete, o_chars_held};
            if (pending_results.size() == 0) begin
                report_fault($sformatf("unexpected result: status %0d data %02h lc %0b chars %0d",
                    seen.status, seen.read_data, seen.line_complete, seen.chars_held));
            end else begin
                want = pending_results.pop_front();
                if (seen.status !== want.status || seen.read_data !== want.read_data ||
                    seen.line_complete !== want.line_complete ||
                    seen.chars_held !== want.chars_held)
                    report_fault($sformatf(
                        "mismatch: exp status %0d data %02h lc %0b chars %0d, got %0d %02h %0b %0d",
                        want.status, want.read_data, want.line_complete, want.chars_held,
                        seen.status, seen.read_data, seen.line_complete, seen.chars_held));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int                n;
        int                stored;
        int                r;
        urlrb_pkg::t_cmd   cmd;
        logic [7:0]        b;
        urlrb_pkg::t_chars occ;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_ascii_mode(1'b1);

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].ascii != ascii_on)
                write_ascii_mode(DIRECTED[k].ascii);
            send_cmd(DIRECTED[k].cmd, DIRECTED[k].data, DIRECTED[k].lit, DIRECTED[k].res);
            hold_push();
        end

        for (int p = 0; p < 5; p++) begin
            write_ascii_mode(PHASE_MODE[p]);
            n = 0;
            stored = 0;
            while (PHASE_KIND[p] == PH_STREAM ? stored < STREAM_TARGET : n < PHASE_LEN[p]) begin
                occ = wr_ptr - rd_ptr;
                r = $urandom_range(0, 99);
                b = pick_byte();
                case (PHASE_KIND[p])
                    PH_FILL: begin
                        if (occ >= 7'd125)
                            cmd = (r < 15) ? urlrb_pkg::CMD_FLUSH :
                                  (r < 55) ? urlrb_pkg::CMD_POP : urlrb_pkg::CMD_BYTE;
                        else
                            cmd = (r < 90) ? urlrb_pkg::CMD_BYTE :
                                  (r < 98) ? urlrb_pkg::CMD_POP :
                                  (r < 99) ? CMD_NOP : urlrb_pkg::CMD_FLUSH;
                    end
                    PH_STREAM: begin
                        // keep the line open: no terminator and no dropped byte codes
                        b = 8'($urandom_range(8'h20, 8'hFF));
                        cmd = (occ >= 7'd110 || r < 15) ? urlrb_pkg::CMD_POP
                                                        : urlrb_pkg::CMD_BYTE;
                    end
                    default: begin
                        cmd = (r < 52) ? urlrb_pkg::CMD_BYTE :
                              (r < 92) ? urlrb_pkg::CMD_POP :
                              (r < 95) ? CMD_NOP : urlrb_pkg::CMD_FLUSH;
                    end
                endcase
                send_cmd(cmd, b, 1'b0, '0);
                if (cmd == urlrb_pkg::CMD_BYTE
                    && pending_results[$].status == urlrb_pkg::ST_STORED)
                    stored++;
                n++;
                hold_push();
            end
            if (PHASE_KIND[p] == PH_STREAM) begin
                send_cmd(urlrb_pkg::CMD_BYTE, urlrb_pkg::BYTE_CR, 1'b0, '0);
                hold_push();
            end
        end

        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        fault_count += pending_results.size();
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
